// ===== src/gld_pkg.sv =====
package gld_pkg;

  localparam int MAX_CODE_BITS = 12;
  localparam int TABLE_SIZE    = 1 << MAX_CODE_BITS;
  localparam int AW            = MAX_CODE_BITS;
  localparam int CNT_W         = MAX_CODE_BITS + 1;
  localparam int WID_W         = $clog2(MAX_CODE_BITS + 1);
  localparam int ENTRY_W       = MAX_CODE_BITS + 8;

  localparam int BUF_W     = 32;
  localparam int BCNT_W    = 6;
  localparam int MIN_W     = 4;
  localparam int CMD_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int PIX_W     = 8;
  localparam int STAT_W    = 3;

  localparam logic [MIN_W-1:0]  MIN_CODE_RESET = 4'd8;
  localparam logic [MIN_W-1:0]  MIN_CODE_LOW   = 4'd2;
  localparam logic [MIN_W-1:0]  MIN_CODE_HIGH  = 4'd8;
  localparam logic [BCNT_W-1:0] LOAD_LIMIT     = 6'd24;
  localparam logic [BCNT_W-1:0] BYTE_BITS      = 6'd8;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd2;

  localparam logic [STAT_W-1:0] STAT_PIXEL     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NEED      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_END       = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd4;
  localparam logic [STAT_W-1:0] STAT_REJECT    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_DECODE,
    ST_WALK,
    ST_WALK_DATA
  } gld_state_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_index;
    logic [STAT_W-1:0] status;
  } gld_res_t;

endpackage

// ===== src/gld_ifs.sv =====
interface gld_in_if import gld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] code_byte;
  logic              final_byte;

  modport source(output valid, cmd, code_byte, final_byte, input ready);
  modport sink(input valid, cmd, code_byte, final_byte, output ready);
endinterface

interface gld_out_if import gld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_index;
  logic [STAT_W-1:0] status;

  modport source(output valid, pixel_index, status, input ready);
  modport sink(input valid, pixel_index, status, output ready);
endinterface

// ===== src/gld_ram.sv =====
module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/gld_core.sv =====
module gld_core import gld_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MIN_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [BYTE_W-1:0] code_byte,
  input  logic              final_byte,
  output logic              res_valid,
  input  logic              res_ready,
  output gld_res_t          res
);

  gld_state_t state, state_next;

  logic [MIN_W-1:0]  min_q;
  logic [MIN_W-1:0]  active_min, active_min_next;
  logic [BUF_W-1:0]  bit_buffer, bit_buffer_next;
  logic [BCNT_W-1:0] bit_count, bit_count_next;
  logic [WID_W-1:0]  code_width, code_width_next;
  logic [CNT_W-1:0]  next_free_code, next_free_code_next;
  logic [CNT_W-1:0]  width_limit, width_limit_next;
  logic [PIX_W-1:0]  first_symbol, first_symbol_next;
  logic [AW-1:0]     previous_code, previous_code_next;
  logic              awaiting_first, awaiting_first_next;
  logic              input_finished, input_finished_next;
  logic [CNT_W-1:0]  stack_count, stack_count_next;
  logic [AW-1:0]     chain_code, chain_code_next;
  logic [AW-1:0]     in_code, in_code_next;

  logic              st_we, st_re;
  logic [AW-1:0]     st_waddr, st_raddr;
  logic [PIX_W-1:0]  st_wdata, st_rdata;
  logic              tb_we, tb_re;
  logic [AW-1:0]     tb_waddr, tb_raddr;
  logic [ENTRY_W-1:0] tb_wdata, tb_rdata;

  logic [CNT_W-1:0]  clr_code;
  logic [AW-1:0]     code;
  logic [CNT_W-1:0]  code_ext;
  logic              have_bits, is_clr, is_end;
  logic              accept, pop_go, walk_more, stack_full;
  logic [MIN_W-1:0]  min_clamped;
  logic [CNT_W-1:0]  start_clr;
  logic [PIX_W-1:0]  lit, walk_sym;
  logic [CNT_W-1:0]  nfc_inc;
  logic [CNT_W-1:0]  stack_dec;

  localparam logic [CNT_W-1:0] TABLE_CNT = CNT_W'(TABLE_SIZE);

  gld_ram #(.WIDTH(PIX_W), .DEPTH(TABLE_SIZE)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // entry holds prefix code in the upper bits and suffix byte below
  gld_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_table (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wdata (tb_wdata),
    .re    (tb_re),
    .raddr (tb_raddr),
    .rdata (tb_rdata)
  );

  assign clr_code   = CNT_W'(1) << active_min;
  assign code       = bit_buffer[AW-1:0] & ((AW'(1) << code_width) - AW'(1));
  assign code_ext   = CNT_W'(code);
  assign have_bits  = bit_count >= BCNT_W'(code_width);
  assign is_clr     = code_ext == clr_code;
  assign is_end     = code_ext == clr_code + CNT_W'(1);
  assign in_ready   = (state == ST_IDLE) && res_ready;
  assign accept     = in_valid && in_ready;
  assign pop_go     = stack_count != '0;
  assign stack_full = stack_count == TABLE_CNT;
  assign walk_more  = (CNT_W'(chain_code) >= clr_code) && !stack_full;
  assign lit        = (code_ext < clr_code) ? code[PIX_W-1:0] : '0;
  assign walk_sym   = (CNT_W'(chain_code) < clr_code) ? chain_code[PIX_W-1:0] : '0;
  assign nfc_inc    = next_free_code + CNT_W'(1);
  assign stack_dec  = stack_count - CNT_W'(1);

  assign min_clamped = (min_q < MIN_CODE_LOW)  ? MIN_CODE_LOW :
                       (min_q > MIN_CODE_HIGH) ? MIN_CODE_HIGH : min_q;
  assign start_clr   = CNT_W'(1) << min_clamped;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_PIXEL) begin
          state_next = pop_go ? ST_POP : ST_DECODE;
        end
      end
      ST_POP: begin
        if (res_ready) state_next = ST_IDLE;
      end
      ST_DECODE: begin
        if (!have_bits || (!is_clr && (is_end || awaiting_first))) begin
          if (res_ready) state_next = ST_IDLE;
        end else if (!is_clr) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_more) begin
          state_next = ST_WALK_DATA;
        end else if (stack_full) begin
          state_next = ST_POP;
        end else if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      ST_WALK_DATA: state_next = ST_WALK;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    active_min_next     = active_min;
    bit_buffer_next     = bit_buffer;
    bit_count_next      = bit_count;
    code_width_next     = code_width;
    next_free_code_next = next_free_code;
    width_limit_next    = width_limit;
    first_symbol_next   = first_symbol;
    previous_code_next  = previous_code;
    awaiting_first_next = awaiting_first;
    input_finished_next = input_finished;
    stack_count_next    = stack_count;
    chain_code_next     = chain_code;
    in_code_next        = in_code;
    res_valid = 1'b0;
    res       = '0;
    st_we     = 1'b0;
    st_waddr  = stack_count[AW-1:0];
    st_wdata  = first_symbol;
    st_re     = 1'b0;
    st_raddr  = stack_dec[AW-1:0];
    tb_we     = 1'b0;
    tb_waddr  = next_free_code[AW-1:0];
    tb_wdata  = {previous_code, walk_sym};
    tb_re     = 1'b0;
    tb_raddr  = chain_code;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_START: begin
              active_min_next     = min_clamped;
              code_width_next     = WID_W'(min_clamped) + WID_W'(1);
              next_free_code_next = start_clr + CNT_W'(2);
              width_limit_next    = start_clr << 1;
              awaiting_first_next = 1'b1;
              stack_count_next    = '0;
              bit_buffer_next     = '0;
              bit_count_next      = '0;
              input_finished_next = 1'b0;
              first_symbol_next   = '0;
              previous_code_next  = '0;
              res_valid  = 1'b1;
              res.status = STAT_OK;
            end
            CMD_LOAD: begin
              res_valid = 1'b1;
              if (input_finished || bit_count > LOAD_LIMIT) begin
                res.status = STAT_REJECT;
              end else begin
                bit_buffer_next     = bit_buffer | (BUF_W'(code_byte) << bit_count);
                bit_count_next      = bit_count + BYTE_BITS;
                input_finished_next = final_byte;
                res.status = STAT_OK;
              end
            end
            CMD_PIXEL: begin
              if (pop_go) begin
                st_re            = 1'b1;
                stack_count_next = stack_dec;
              end
            end
            default: begin
              res_valid  = 1'b1;
              res.status = STAT_REJECT;
            end
          endcase
        end
      end
      ST_POP: begin
        res_valid       = 1'b1;
        res.pixel_index = st_rdata;
        res.status      = STAT_PIXEL;
      end
      ST_DECODE: begin
        if (!have_bits) begin
          res_valid  = 1'b1;
          res.status = input_finished ? STAT_EXHAUSTED : STAT_NEED;
        end else if (is_clr) begin
          bit_buffer_next     = bit_buffer >> code_width;
          bit_count_next      = bit_count - BCNT_W'(code_width);
          code_width_next     = WID_W'(active_min) + WID_W'(1);
          next_free_code_next = clr_code + CNT_W'(2);
          width_limit_next    = clr_code << 1;
          awaiting_first_next = 1'b1;
          stack_count_next    = '0;
        end else if (is_end || awaiting_first) begin
          res_valid       = 1'b1;
          res.status      = is_end ? STAT_END : STAT_PIXEL;
          res.pixel_index = is_end ? '0 : lit;
          if (res_ready) begin
            bit_buffer_next = bit_buffer >> code_width;
            bit_count_next  = bit_count - BCNT_W'(code_width);
            if (!is_end) begin
              first_symbol_next   = lit;
              previous_code_next  = AW'(lit);
              awaiting_first_next = 1'b0;
            end
          end
        end else begin
          bit_buffer_next = bit_buffer >> code_width;
          bit_count_next  = bit_count - BCNT_W'(code_width);
          if (code_ext >= next_free_code) begin
            // code not yet in the table: string of previous code plus its first symbol
            st_we            = 1'b1;
            stack_count_next = stack_count + CNT_W'(1);
            chain_code_next  = previous_code;
            in_code_next     = next_free_code[AW-1:0];
          end else begin
            chain_code_next = code;
            in_code_next    = code;
          end
        end
      end
      ST_WALK: begin
        if (walk_more) begin
          tb_re = 1'b1;
        end else if (stack_full || res_ready) begin
          first_symbol_next  = walk_sym;
          previous_code_next = in_code;
          if (next_free_code < TABLE_CNT) begin
            tb_we               = 1'b1;
            next_free_code_next = nfc_inc;
            if (nfc_inc >= width_limit && width_limit < TABLE_CNT) begin
              width_limit_next = width_limit << 1;
              code_width_next  = code_width + WID_W'(1);
            end
          end
          if (stack_full) begin
            st_re            = 1'b1;
            stack_count_next = stack_dec;
          end
        end
        if (!walk_more && !stack_full) begin
          // push and pop of the first symbol cancel, so it goes straight out
          res_valid       = 1'b1;
          res.pixel_index = walk_sym;
          res.status      = STAT_PIXEL;
        end
      end
      ST_WALK_DATA: begin
        st_we            = 1'b1;
        st_wdata         = tb_rdata[PIX_W-1:0];
        stack_count_next = stack_count + CNT_W'(1);
        chain_code_next  = tb_rdata[ENTRY_W-1:PIX_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      min_q          <= MIN_CODE_RESET;
      active_min     <= MIN_CODE_RESET;
      bit_buffer     <= '0;
      bit_count      <= '0;
      code_width     <= WID_W'(MIN_CODE_RESET) + WID_W'(1);
      next_free_code <= (CNT_W'(1) << MIN_CODE_RESET) + CNT_W'(2);
      width_limit    <= CNT_W'(1) << (MIN_CODE_RESET + MIN_W'(1));
      first_symbol   <= '0;
      previous_code  <= '0;
      awaiting_first <= 1'b1;
      input_finished <= 1'b0;
      stack_count    <= '0;
      chain_code     <= '0;
      in_code        <= '0;
    end else begin
      state          <= state_next;
      if (cfg_we) min_q <= cfg_wdata;
      active_min     <= active_min_next;
      bit_buffer     <= bit_buffer_next;
      bit_count      <= bit_count_next;
      code_width     <= code_width_next;
      next_free_code <= next_free_code_next;
      width_limit    <= width_limit_next;
      first_symbol   <= first_symbol_next;
      previous_code  <= previous_code_next;
      awaiting_first <= awaiting_first_next;
      input_finished <= input_finished_next;
      stack_count    <= stack_count_next;
      chain_code     <= chain_code_next;
      in_code        <= in_code_next;
    end
  end

endmodule

// ===== src/gif_lzw_decoder.sv =====
// start, load, unknown commands: result registered, 1 item/cycle unless the output stalls
// pixel request with a non-empty stack: answered from the stack memory read in ST_POP
// pixel request that decodes: a status or the first code after start or clear is answered
//   from ST_DECODE; other codes walk the table in ST_WALK/ST_WALK_DATA (table memory read),
//   clear codes add ST_DECODE, a full stack ST_POP; a code with chain length n gives n pixels
// reset: synchronous, as after a start with minimum code size 8; memories are not cleared
module gif_lzw_decoder import gld_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [MIN_W-1:0] cfg_wdata,
  gld_in_if.sink           req,
  gld_out_if.source        rsp
);

  logic     res_valid, res_ready;
  gld_res_t res;
  logic     out_valid;
  gld_res_t out_q;

  assign res_ready = !out_valid || rsp.ready;

  gld_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .cmd        (req.cmd),
    .code_byte  (req.code_byte),
    .final_byte (req.final_byte),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pixel_index = out_q.pixel_index;
  assign rsp.status      = out_q.status;

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (!rsp.valid || rsp.ready))
    else $error("input taken with no room for its result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status <= STAT_REJECT))
    else $error("status code out of range");

  a_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != STAT_PIXEL) |-> rsp.pixel_index == '0)
    else $error("pixel index not zero on a status result");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("core dropped a stalled result");

endmodule
